[sv/kms_pkg.sv]
// ----------------------------------------------------------------------------
// kms_pkg
// shared types and constants of the matrix keypad scanner
// ----------------------------------------------------------------------------
package kms_pkg;

    localparam int LINE_LIMIT       = 5;
    localparam int ROW_COUNT_DEF    = 5;
    localparam int COLUMN_COUNT_DEF = 5;
    localparam int LINE_W           = 5;
    localparam int ROW_IDX_W        = 3;
    localparam int COL_IDX_W        = 3;
    localparam int KEY_W            = 5;
    localparam int DTMF_LAST_ROW    = 3;
    localparam int DTMF_LAST_COL    = 2;

    localparam logic [LINE_W-1:0] ALL_HIGH = 5'h1f;
    localparam logic [LINE_W-1:0] ALL_LOW  = 5'h00;

    typedef enum logic [1:0] {
        EV_NONE    = 2'd0,
        EV_PRESS   = 2'd1,
        EV_RELEASE = 2'd2
    } event_kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_HELD
    } scan_state_t;

    typedef struct packed {
        logic [LINE_W-1:0] row_drive;
        event_kind_t       event_kind;
        logic [KEY_W-1:0]  key_index;
        logic              is_dtmf;
    } kms_result_t;

endpackage

[sv/kms_core.sv]
// ----------------------------------------------------------------------------
// kms_core
// scan state machine: one column sample per step, row drive and key events
// ----------------------------------------------------------------------------
module kms_core
    import kms_pkg::*;
#(
    parameter int ROW_COUNT    = ROW_COUNT_DEF,
    parameter int COLUMN_COUNT = COLUMN_COUNT_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step_en,
    input  logic [LINE_W-1:0] column_sense,
    output kms_result_t       result
);

    localparam int EFF_ROWS = (ROW_COUNT > LINE_LIMIT) ? LINE_LIMIT : ROW_COUNT;
    localparam int EFF_COLS = (COLUMN_COUNT > LINE_LIMIT) ? LINE_LIMIT : COLUMN_COUNT;
    localparam logic [LINE_W-1:0] COL_MASK = LINE_W'((1 << EFF_COLS) - 1);
    localparam logic [ROW_IDX_W-1:0] LAST_ROW = ROW_IDX_W'(EFF_ROWS - 1);

    scan_state_t           state_reg, state_next;
    logic [ROW_IDX_W-1:0]  scan_row_reg, scan_row_next;
    logic [LINE_W-1:0]     row_levels_reg, row_levels_next;

    logic [LINE_W-1:0]     sense;
    logic                  any_low;
    logic [COL_IDX_W-1:0]  first_col;
    logic [KEY_W:0]        key_sum;
    logic [ROW_IDX_W-1:0]  row_inc;

    assign sense   = column_sense & COL_MASK;
    assign any_low = (sense != COL_MASK);
    assign row_inc = scan_row_reg + ROW_IDX_W'(1);

    // lowest low column wins
    always_comb begin
        first_col = COL_IDX_W'(EFF_COLS);
        for (int c = EFF_COLS - 1; c >= 0; c--) begin
            if (!sense[c]) begin
                first_col = COL_IDX_W'(c);
            end
        end
    end

    assign key_sum = (KEY_W+1)'(scan_row_reg) * (KEY_W+1)'(EFF_COLS)
                   + (KEY_W+1)'(first_col);

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (any_low) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (any_low) begin
                    state_next = ST_HELD;
                end else if (scan_row_reg >= LAST_ROW) begin
                    state_next = ST_IDLE;
                end
            end
            ST_HELD: begin
                if (!any_low) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs and datapath
    always_comb begin
        scan_row_next     = scan_row_reg;
        row_levels_next   = row_levels_reg;
        result.event_kind = EV_NONE;
        result.key_index  = '0;
        result.is_dtmf    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (any_low) begin
                    scan_row_next   = '0;
                    row_levels_next = ALL_HIGH & ~LINE_W'(1);
                end
            end
            ST_SCAN: begin
                if (any_low) begin
                    result.event_kind = EV_PRESS;
                    result.key_index  = key_sum[KEY_W-1:0];
                    result.is_dtmf    = (scan_row_reg <= ROW_IDX_W'(DTMF_LAST_ROW))
                                     && (first_col <= COL_IDX_W'(DTMF_LAST_COL));
                end else if (scan_row_reg >= LAST_ROW) begin
                    scan_row_next   = '0;
                    row_levels_next = ALL_LOW;
                end else begin
                    scan_row_next   = row_inc;
                    row_levels_next = ALL_HIGH & ~(LINE_W'(1) << row_inc);
                end
            end
            ST_HELD: begin
                if (!any_low) begin
                    row_levels_next   = ALL_LOW;
                    result.event_kind = EV_RELEASE;
                end
            end
            default: begin
                scan_row_next   = '0;
                row_levels_next = ALL_LOW;
            end
        endcase
        result.row_drive = row_levels_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            scan_row_reg   <= '0;
            row_levels_reg <= ALL_LOW;
        end else if (step_en) begin
            state_reg      <= state_next;
            scan_row_reg   <= scan_row_next;
            row_levels_reg <= row_levels_next;
        end
    end

endmodule

[sv/keypad_matrix_scanner.sv]
// ----------------------------------------------------------------------------
// keypad_matrix_scanner
// single-key matrix keypad scanner with stream input and result channels
// ----------------------------------------------------------------------------
//  channel | dir | payload
//  s_      | in  | tdata[4:0] column_sense
//  m_      | out | tdata[4:0] row_drive, tdata[9:5] key_index,
//          |     | tuser[1:0] event_kind, tuser[2] is_dtmf
//
//  one word in, one word out; a word passes from s_ to m_ through
//  the input register, then the scan step into the result register
//  sustained rate is one word per cycle while m_tready stays high
//  aresetn (sync, active low) clears valid flags and the scan state
//  a stalled m_ side holds the result; the input register keeps taking
//  a word while it is empty or while the result register frees up in the same cycle
// ----------------------------------------------------------------------------
module keypad_matrix_scanner
    import kms_pkg::*;
#(
    parameter int ROW_COUNT    = ROW_COUNT_DEF,
    parameter int COLUMN_COUNT = COLUMN_COUNT_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [4:0] column_sense, [7:5] zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [4:0] row_drive, [9:5] key_index, [15:10] zero
    output logic [2:0]  m_tuser    // [1:0] event_kind, [2] is_dtmf
);

    logic              in_valid_reg;
    logic [LINE_W-1:0] in_data_reg;
    logic              out_valid_reg;
    kms_result_t       out_reg;
    kms_result_t       step_result;
    logic              advance;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    kms_core #(
        .ROW_COUNT    (ROW_COUNT),
        .COLUMN_COUNT (COLUMN_COUNT)
    ) u_core (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .step_en      (advance),
        .column_sense (in_data_reg),
        .result       (step_result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_data_reg <= s_tdata[LINE_W-1:0];
        end
        if (advance) begin
            out_reg <= step_result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b0, out_reg.key_index, out_reg.row_drive};
    assign m_tuser  = {out_reg.is_dtmf, out_reg.event_kind};

endmodule
